FILE: design/box3_pkg.sv
`default_nettype none

package box3_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 12;
  localparam int SIZE_BITS   = 13;
  localparam int COUNT_LIMIT = 4096;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // sum of nine samples and its magnitude plus the rounding offset
  localparam int SUM_BITS = SAMPLE_BITS + 4;
  localparam int MAG_BITS = SAMPLE_BITS + 3;

  // divide by nine as multiply by ceil(2^k / 9), exact for every magnitude
  localparam int RECIP_SHIFT = MAG_BITS + 4;
  localparam int RECIP_BITS  = MAG_BITS + 2;
  localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
  localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(((2 ** RECIP_SHIFT) + 8) / 9);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // the two stored rows at one column
  typedef struct packed {
    sample_t older;
    sample_t newer;
  } line_pair_t;

  // position and end-of-frame flag riding along with a result
  typedef struct packed {
    logic [COUNT_BITS-1:0] row;
    logic [COUNT_BITS-1:0] col;
    logic                  last;
  } meta_t;

endpackage

`default_nettype wire

FILE: design/box_filter_3x3_stream.sv
`default_nettype none

// channel   dir  handshake                     payload
// --------  ---  ----------------------------  -------------------------------------------
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample; tuser: frame_start
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: mean, center row, center col;
//                                              tlast: frame_last
// cfg       in   cfg_we_i (no wait)            cfg_idx_i selects width or height
//
// one word per clock sustained while m_axis_tready stays high; a result shows up on m_axis
// once the word and its line-buffer read have sat in stage a and then passed through the
// nine-sample sum, the rounded magnitude, the reciprocal product and the output
// register, each registered in turn
// reset clears counters, window and stage valid bits and sets the size registers to
// width 100 and height 200; the line buffers are not cleared and need no clearing pass
// border words carry no result and drop out after the window stage, so the input
// keeps flowing while a result waits for m_axis_tready until the stages fill up

module box_filter_3x3_stream #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave side
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [15:0] sample
  input  wire  [0:0]  s_axis_tuser,   // [0] frame_start
  // master side
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] mean_value, [27:16] center_row,
                                      // [39:28] center_col
  output logic        m_axis_tlast,   // frame_last
  // configuration
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_idx_i,
  input  wire  [12:0] cfg_wdata_i
);
  import box3_pkg::*;

  localparam int AddrBits  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SizeLimit = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
  localparam logic [SIZE_BITS-1:0] SizeMax = SIZE_BITS'(SizeLimit);
  localparam logic [SIZE_BITS-1:0] SizeMin = SIZE_BITS'(3);

  // ---------------------------------------------------------------------------
  // configuration registers and effective last indexes
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0]  width_q, height_q;
  logic [COUNT_BITS-1:0] w_last, h_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_BITS'(100);
      height_q <= SIZE_BITS'(200);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp to 3..limit, then last index = size - 1
  always_comb begin
    if (width_q < SizeMin) begin
      w_last = COUNT_BITS'(SizeMin - 1'b1);
    end else if (width_q > SizeMax) begin
      w_last = COUNT_BITS'(SizeMax - 1'b1);
    end else begin
      w_last = COUNT_BITS'(width_q - 1'b1);
    end
    if (height_q < SizeMin) begin
      h_last = COUNT_BITS'(SizeMin - 1'b1);
    end else if (height_q > SizeMax) begin
      h_last = COUNT_BITS'(SizeMax - 1'b1);
    end else begin
      h_last = COUNT_BITS'(height_q - 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // stage valid bits and flow control
  // ---------------------------------------------------------------------------
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, o_vld_q;
  logic ld_o, ld_d, ld_c, ld_b, a_emit, a_move, s_accept;

  // a stage may load when it is empty or its word moves on this edge
  assign ld_o     = !o_vld_q || m_axis_tready;
  assign ld_d     = !d_vld_q || ld_o;
  assign ld_c     = !c_vld_q || ld_d;
  assign ld_b     = !b_vld_q || ld_c;
  // border words never need a slot beyond the window stage
  assign a_move   = a_vld_q && (!a_emit || ld_b);
  assign s_axis_tready = !a_vld_q || a_move;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // position counters, stepped as each word is taken
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] row_q, col_q, row_in, col_in;
  logic [AddrBits-1:0]   rd_addr;

  assign row_in  = s_axis_tuser[0] ? '0 : row_q;
  assign col_in  = s_axis_tuser[0] ? '0 : col_q;
  assign rd_addr = AddrBits'(col_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (s_accept) begin
      if (col_in >= w_last) begin
        col_q <= '0;
        // wrap the row at the end of the frame
        row_q <= (row_in >= h_last) ? '0 : row_in + 1'b1;
      end else begin
        col_q <= col_in + 1'b1;
        row_q <= row_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: input word plus the two stored rows at its column
  // ---------------------------------------------------------------------------
  sample_t               a_cur_q;
  logic [COUNT_BITS-1:0] a_row_q, a_col_q;
  line_pair_t            a_up;
  line_pair_t            wr_pair;
  logic                  a_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      a_cur_q <= sample_t'(s_axis_tdata);
      a_row_q <= row_in;
      a_col_q <= col_in;
    end
  end

  // the entry at a column is rewritten as its word leaves stage a; the next
  // read of that column comes at least one row of words later
  assign wr_pair.older = a_up.newer;
  assign wr_pair.newer = a_cur_q;

  box3_line_ram #(
    .DEPTH     (MAX_WIDTH),
    .ADDR_BITS (AddrBits)
  ) u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (s_accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (a_up),
    .wr_en_i   (a_move),
    .wr_addr_i (AddrBits'(a_col_q)),
    .wr_data_i (wr_pair)
  );

  assign a_emit = (a_row_q >= COUNT_BITS'(2)) && (a_col_q >= COUNT_BITS'(2));
  assign a_last = (a_row_q >= h_last) && (a_col_q >= w_last);

  // 3x3 window: entries 0..2 hold column c-2, 3..5 column c-1 (older, newer, current)
  sample_t win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (a_move) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= a_up.older;
      win_q[4] <= a_up.newer;
      win_q[5] <= a_cur_q;
    end
  end

  // exact sum of the nine samples
  logic signed [SUM_BITS-1:0] a_sum;

  always_comb begin
    a_sum = SUM_BITS'(a_up.older) + SUM_BITS'(a_up.newer) + SUM_BITS'(a_cur_q);
    for (int i = 0; i < 6; i++) begin
      a_sum = a_sum + SUM_BITS'(win_q[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: sum; stage c: magnitude plus rounding offset; stage d: product
  // ---------------------------------------------------------------------------
  logic signed [SUM_BITS-1:0] b_sum_q;
  meta_t                      b_meta_q, c_meta_q, d_meta_q, o_meta_q;
  logic [SUM_BITS-1:0]        b_abs;
  logic [MAG_BITS-1:0]        c_mag_q;
  logic                       c_neg_q, d_neg_q;
  logic [PROD_BITS-1:0]       d_prod_q;
  logic [QUOT_BITS-1:0]       d_quot, d_signed;
  sample_t                    o_mean_q;

  assign b_abs  = b_sum_q[SUM_BITS-1] ? (-b_sum_q) : b_sum_q;
  assign d_quot = d_prod_q[PROD_BITS-1:RECIP_SHIFT];
  // round half away from zero: sign is applied to the rounded magnitude
  assign d_signed = d_neg_q ? (-d_quot) : d_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (ld_b) begin
        b_vld_q <= a_vld_q && a_emit;
      end
      if (ld_c) begin
        c_vld_q <= b_vld_q;
      end
      if (ld_d) begin
        d_vld_q <= c_vld_q;
      end
      if (ld_o) begin
        o_vld_q <= d_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_b && a_vld_q && a_emit) begin
      b_sum_q       <= a_sum;
      b_meta_q.row  <= a_row_q - 1'b1;
      b_meta_q.col  <= a_col_q - 1'b1;
      b_meta_q.last <= a_last;
    end
    if (ld_c && b_vld_q) begin
      c_neg_q  <= b_sum_q[SUM_BITS-1];
      c_mag_q  <= MAG_BITS'(b_abs) + MAG_BITS'(4);
      c_meta_q <= b_meta_q;
    end
    if (ld_d && c_vld_q) begin
      d_neg_q  <= c_neg_q;
      d_prod_q <= PROD_BITS'(c_mag_q) * PROD_BITS'(RECIP);
      d_meta_q <= c_meta_q;
    end
    if (ld_o && d_vld_q) begin
      o_mean_q <= sample_t'(d_signed[SAMPLE_BITS-1:0]);
      o_meta_q <= d_meta_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output word
  // ---------------------------------------------------------------------------
  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {o_meta_q.col, o_meta_q.row, o_mean_q};
  assign m_axis_tlast  = o_meta_q.last;

endmodule

`default_nettype wire

FILE: design/box3_line_ram.sv
`default_nettype none

module box3_line_ram #(
  parameter int unsigned DEPTH     = 4096,
  parameter int unsigned ADDR_BITS = 12
) (
  input  wire                       clk_i,
  input  wire                       rd_en_i,
  input  wire [ADDR_BITS-1:0]       rd_addr_i,
  output box3_pkg::line_pair_t      rd_data_o,
  input  wire                       wr_en_i,
  input  wire [ADDR_BITS-1:0]       wr_addr_i,
  input  box3_pkg::line_pair_t      wr_data_i
);
  import box3_pkg::*;

  line_pair_t mem [DEPTH];
  line_pair_t rd_data_q;

  // read before write on a shared address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
